// ===== rtl/core/esc_dmt_pkg.sv =====
`default_nettype none

package esc_dmt_pkg;

  // Register map of the configuration port
  localparam logic [2:0] REG_CONTROLLER_MODE       = 3'd0;
  localparam logic [2:0] REG_NEUTRAL_BAND_WIDE     = 3'd1;
  localparam logic [2:0] REG_NEUTRAL_BAND_NARROW   = 3'd2;
  localparam logic [2:0] REG_DISARM_TICKS          = 3'd3;
  localparam logic [2:0] REG_FORWARD_AUTO_BRAKE_ON = 3'd4;
  localparam logic [2:0] REG_REVERSE_AUTO_BRAKE_ON = 3'd5;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 10;

  // Controller modes
  localparam logic [1:0] MODE_FWD_REV           = 2'd0;
  localparam logic [1:0] MODE_FWD_BRAKE         = 2'd1;
  localparam logic [1:0] MODE_FWD_BRAKE_REV     = 2'd2;
  localparam logic [1:0] MODE_FWD_BRAKE_REV_TMO = 2'd3;

  // Item operations
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int DRAW_BITS = 10;

  typedef struct packed {
    logic                 operation;
    logic signed [7:0]    throttle;
    logic [DRAW_BITS-1:0] brake_hold_draw;
    logic [DRAW_BITS-1:0] reverse_hold_draw;
  } item_t;

  typedef struct packed {
    logic going_forward;
    logic going_reverse;
    logic brake_light;
    logic armed;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/esc_drive_mode_tracker_top.sv =====
`default_nettype none

// ESC drive mode tracker. Each item is either one system tick or one new
// throttle sample, and each item yields exactly one result carrying the
// forward, reverse, brake and armed flags after the item is applied. The
// block takes one item per clock while item_stall is low: the whole flag and
// countdown update is one short combinational step from the state registers
// and the incoming item into the next state and the result register, so the
// next item can follow in the very next cycle. The result is registered.
// The result register decouples the two channels; item_stall rises only
// while a result is held and the downstream side stalls it. Throttle
// magnitude is compared strictly below a neutral band with hysteresis: the
// wide band applies while in neutral, the narrow band while driving. Hold
// draws of zero load one tick; draws above the counter range saturate.
// Configuration (cfg_ready is always high) must be written only while idle.
module esc_drive_mode_tracker_top #(
  parameter int COUNT_BITS = 10
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  item_valid,
  output logic                                 item_stall,
  input  esc_dmt_pkg::item_t                   item,
  output logic                                 result_valid,
  input  wire                                  result_stall,
  output esc_dmt_pkg::result_t                 result,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [esc_dmt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [esc_dmt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import esc_dmt_pkg::*;

  localparam int LOAD_BITS = (COUNT_BITS > DRAW_BITS) ? COUNT_BITS : DRAW_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Saturate a hold value into the counter range, zero becomes one tick.
  function automatic logic [COUNT_BITS-1:0] hold_load(input logic [DRAW_BITS-1:0] v);
    logic [LOAD_BITS-1:0] ext;
    logic [LOAD_BITS-1:0] cmax;
    ext  = LOAD_BITS'(v);
    cmax = LOAD_BITS'({COUNT_BITS{1'b1}});
    if (v == '0) begin
      return COUNT_ONE;
    end else if (ext > cmax) begin
      return {COUNT_BITS{1'b1}};
    end else begin
      return ext[COUNT_BITS-1:0];
    end
  endfunction

  // Configuration registers
  logic [1:0]           controller_mode;
  logic [7:0]           neutral_band_wide;
  logic [7:0]           neutral_band_narrow;
  logic [DRAW_BITS-1:0] disarm_ticks;
  logic                 forward_auto_brake_on;
  logic                 reverse_auto_brake_on;

  // Tracker state
  logic                  in_neutral, fwd_flag, rev_flag, brk_flag, armed_flag;
  logic                  disarm_pending, auto_brake_active, auto_reverse_active;
  logic [COUNT_BITS-1:0] disarm_count, auto_brake_count, auto_reverse_count;

  logic                  in_neutral_next, fwd_flag_next, rev_flag_next;
  logic                  brk_flag_next, armed_flag_next, disarm_pending_next;
  logic                  auto_brake_active_next, auto_reverse_active_next;
  logic [COUNT_BITS-1:0] disarm_count_next, auto_brake_count_next;
  logic [COUNT_BITS-1:0] auto_reverse_count_next;

  logic       item_accept;
  logic       back;
  logic [8:0] mag;
  logic [7:0] band;
  logic       is_neutral;

  assign cfg_ready   = 1'b1;
  assign item_stall  = result_valid & result_stall;
  assign item_accept = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_mode       <= MODE_FWD_BRAKE_REV;
      neutral_band_wide     <= 8'd12;
      neutral_band_narrow   <= 8'd8;
      disarm_ticks          <= DRAW_BITS'(50);
      forward_auto_brake_on <= 1'b1;
      reverse_auto_brake_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CONTROLLER_MODE:       controller_mode       <= cfg_data[1:0];
        REG_NEUTRAL_BAND_WIDE:     neutral_band_wide     <= cfg_data[7:0];
        REG_NEUTRAL_BAND_NARROW:   neutral_band_narrow   <= cfg_data[7:0];
        REG_DISARM_TICKS:          disarm_ticks          <= cfg_data;
        REG_FORWARD_AUTO_BRAKE_ON: forward_auto_brake_on <= cfg_data[0];
        REG_REVERSE_AUTO_BRAKE_ON: reverse_auto_brake_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Throttle magnitude; -128 gives 128
  assign back       = item.throttle[7];
  assign mag        = back ? (9'd256 - {1'b0, item.throttle}) : {1'b0, item.throttle};
  assign band       = in_neutral ? neutral_band_wide : neutral_band_narrow;
  assign is_neutral = mag < {1'b0, band};

  always_comb begin
    in_neutral_next          = in_neutral;
    fwd_flag_next            = fwd_flag;
    rev_flag_next            = rev_flag;
    brk_flag_next            = brk_flag;
    armed_flag_next          = armed_flag;
    disarm_pending_next      = disarm_pending;
    auto_brake_active_next   = auto_brake_active;
    auto_reverse_active_next = auto_reverse_active;
    disarm_count_next        = disarm_count;
    auto_brake_count_next    = auto_brake_count;
    auto_reverse_count_next  = auto_reverse_count;

    if (item.operation == OP_TICK) begin
      // countdowns run down, flags clear at zero
      if (disarm_pending) begin
        disarm_count_next = disarm_count - COUNT_ONE;
        if (disarm_count_next == '0) begin
          disarm_pending_next = 1'b0;
          armed_flag_next     = 1'b0;
        end
      end
      if (auto_brake_active) begin
        auto_brake_count_next = auto_brake_count - COUNT_ONE;
        if (auto_brake_count_next == '0) begin
          auto_brake_active_next = 1'b0;
          brk_flag_next          = 1'b0;
        end
      end
      if (auto_reverse_active) begin
        auto_reverse_count_next = auto_reverse_count - COUNT_ONE;
        if (auto_reverse_count_next == '0) begin
          auto_reverse_active_next = 1'b0;
          rev_flag_next            = 1'b0;
        end
      end
    end else if (is_neutral) begin
      in_neutral_next = 1'b1;
      if (fwd_flag) begin
        fwd_flag_next = 1'b0;
        if (controller_mode == MODE_FWD_BRAKE_REV_TMO) begin
          disarm_pending_next = 1'b1;
          disarm_count_next   = hold_load(disarm_ticks);
        end
        if (forward_auto_brake_on) begin
          brk_flag_next          = 1'b1;
          auto_brake_active_next = 1'b1;
          auto_brake_count_next  = hold_load(item.brake_hold_draw);
        end
      end else if (rev_flag) begin
        if (!auto_reverse_active) begin
          auto_reverse_active_next = 1'b1;
          auto_reverse_count_next  = hold_load(item.reverse_hold_draw);
          if (reverse_auto_brake_on) begin
            brk_flag_next          = 1'b1;
            auto_brake_active_next = 1'b1;
            auto_brake_count_next  = hold_load(item.brake_hold_draw);
          end
        end
      end else if (brk_flag && !auto_brake_active) begin
        // manual brake released in neutral
        armed_flag_next = 1'b0;
        brk_flag_next   = 1'b0;
      end
    end else begin
      in_neutral_next        = 1'b0;
      auto_brake_active_next = 1'b0;
      disarm_pending_next    = 1'b0;
      if (back) begin
        fwd_flag_next = 1'b0;
        if (controller_mode == MODE_FWD_BRAKE || armed_flag) begin
          brk_flag_next = 1'b1;
          rev_flag_next = 1'b0;
        end else begin
          rev_flag_next            = 1'b1;
          brk_flag_next            = 1'b0;
          auto_reverse_active_next = 1'b0;
        end
      end else begin
        fwd_flag_next = 1'b1;
        rev_flag_next = 1'b0;
        brk_flag_next = 1'b0;
        if (controller_mode != MODE_FWD_REV) begin
          armed_flag_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_neutral          <= 1'b1;
      fwd_flag            <= 1'b0;
      rev_flag            <= 1'b0;
      brk_flag            <= 1'b0;
      armed_flag          <= 1'b0;
      disarm_pending      <= 1'b0;
      auto_brake_active   <= 1'b0;
      auto_reverse_active <= 1'b0;
      disarm_count        <= '0;
      auto_brake_count    <= '0;
      auto_reverse_count  <= '0;
    end else if (item_accept) begin
      in_neutral          <= in_neutral_next;
      fwd_flag            <= fwd_flag_next;
      rev_flag            <= rev_flag_next;
      brk_flag            <= brk_flag_next;
      armed_flag          <= armed_flag_next;
      disarm_pending      <= disarm_pending_next;
      auto_brake_active   <= auto_brake_active_next;
      auto_reverse_active <= auto_reverse_active_next;
      disarm_count        <= disarm_count_next;
      auto_brake_count    <= auto_brake_count_next;
      auto_reverse_count  <= auto_reverse_count_next;
    end
  end

  // Result register: refilled on every item transfer, held while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      result.going_forward <= fwd_flag_next;
      result.going_reverse <= rev_flag_next;
      result.brake_light   <= brk_flag_next;
      result.armed         <= armed_flag_next;
    end
  end

  // Forward drive is never flagged while the wide band is selected
  a_fwd_not_neutral: assert property (@(posedge clk) disable iff (rst)
    fwd_flag |-> !in_neutral)
    else $error("forward flag set while in neutral");

  // A running auto-brake countdown always shows the brake light
  a_auto_brake_lit: assert property (@(posedge clk) disable iff (rst)
    auto_brake_active |-> brk_flag)
    else $error("auto brake active without brake flag");

  // Every transferred item leaves a result in the output register
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_accept |=> result_valid)
    else $error("item transfer without result");

endmodule

`default_nettype wire

// ===== verif/tb_esc_drive_mode_tracker_top.sv =====
`timescale 1ns / 100ps

import esc_dmt_pkg::*;

// Predicts the drive flags item by item and checks the block's results in order.
class drive_mode_scoreboard #(parameter int CW = 10);
  // configuration copy
  logic [1:0] mode;
  logic [7:0] band_wide;
  logic [7:0] band_narrow;
  logic [9:0] disarm_ticks;
  logic       fwd_auto_brake;
  logic       rev_auto_brake;
  // drive state
  logic in_neutral, fwd, rev, brk, armed;
  logic disarm_pending, brake_hold_on, rev_hold_on;
  logic [CW-1:0] disarm_cnt, brake_cnt, rev_cnt;
  result_t flags_due[$];
  int mismatches;

  function void clear();
    mode           = MODE_FWD_BRAKE_REV;
    band_wide      = 8'd12;
    band_narrow    = 8'd8;
    disarm_ticks   = 10'd50;
    fwd_auto_brake = 1'b1;
    rev_auto_brake = 1'b1;
    in_neutral     = 1'b1;
    {fwd, rev, brk, armed} = '0;
    {disarm_pending, brake_hold_on, rev_hold_on} = '0;
    disarm_cnt = '0;
    brake_cnt  = '0;
    rev_cnt    = '0;
    flags_due.delete();
    mismatches = 0;
  endfunction

  function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_CONTROLLER_MODE:       mode = data[1:0];
      REG_NEUTRAL_BAND_WIDE:     band_wide = data[7:0];
      REG_NEUTRAL_BAND_NARROW:   band_narrow = data[7:0];
      REG_DISARM_TICKS:          disarm_ticks = data[9:0];
      REG_FORWARD_AUTO_BRAKE_ON: fwd_auto_brake = data[0];
      REG_REVERSE_AUTO_BRAKE_ON: rev_auto_brake = data[0];
      default: ;
    endcase
  endfunction

  // zero loads one tick, anything past the counter range saturates
  function logic [CW-1:0] hold_ticks(logic [9:0] draw);
    int unsigned top;
    top = (1 << CW) - 1;
    if (draw == 0) return CW'(1);
    if (draw > top) return CW'(top);
    return CW'(draw);
  endfunction

  function int pending();
    return flags_due.size();
  endfunction

  function void note_item(item_t it);
    logic [7:0]  raw;
    logic        back;
    int unsigned mag;
    int unsigned band;
    result_t     r;
    if (it.operation == OP_TICK) begin
      if (disarm_pending) begin
        disarm_cnt = disarm_cnt - CW'(1);
        if (disarm_cnt == '0) begin
          disarm_pending = 1'b0;
          armed = 1'b0;
        end
      end
      if (brake_hold_on) begin
        brake_cnt = brake_cnt - CW'(1);
        if (brake_cnt == '0) begin
          brake_hold_on = 1'b0;
          brk = 1'b0;
        end
      end
      if (rev_hold_on) begin
        rev_cnt = rev_cnt - CW'(1);
        if (rev_cnt == '0) begin
          rev_hold_on = 1'b0;
          rev = 1'b0;
        end
      end
    end else begin
      raw  = it.throttle;
      back = raw[7];
      mag  = back ? 32'd256 - 32'(raw) : 32'(raw);
      band = in_neutral ? 32'(band_wide) : 32'(band_narrow);
      if (mag < band) begin
        in_neutral = 1'b1;
        if (fwd) begin
          fwd = 1'b0;
          if (mode == MODE_FWD_BRAKE_REV_TMO) begin
            disarm_pending = 1'b1;
            disarm_cnt = hold_ticks(disarm_ticks);
          end
          if (fwd_auto_brake) begin
            brk = 1'b1;
            brake_hold_on = 1'b1;
            brake_cnt = hold_ticks(it.brake_hold_draw);
          end
        end else if (rev) begin
          if (!rev_hold_on) begin
            rev_hold_on = 1'b1;
            rev_cnt = hold_ticks(it.reverse_hold_draw);
            if (rev_auto_brake) begin
              brk = 1'b1;
              brake_hold_on = 1'b1;
              brake_cnt = hold_ticks(it.brake_hold_draw);
            end
          end
        end else if (brk && !brake_hold_on) begin
          armed = 1'b0;
          brk = 1'b0;
        end
      end else begin
        in_neutral = 1'b0;
        brake_hold_on = 1'b0;
        disarm_pending = 1'b0;
        if (back) begin
          fwd = 1'b0;
          if (mode == MODE_FWD_BRAKE || armed) begin
            brk = 1'b1;
            rev = 1'b0;
          end else begin
            rev = 1'b1;
            brk = 1'b0;
            rev_hold_on = 1'b0;
          end
        end else begin
          fwd = 1'b1;
          rev = 1'b0;
          brk = 1'b0;
          if (mode != MODE_FWD_REV) armed = 1'b1;
        end
      end
    end
    r.going_forward = fwd;
    r.going_reverse = rev;
    r.brake_light   = brk;
    r.armed         = armed;
    flags_due.push_back(r);
  endfunction

  function void flag_field(string field, logic want, logic got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected %b, got %b", $realtime, field, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (flags_due.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: result %b with nothing expected", $realtime, got);
      mismatches++;
      return;
    end
    want = flags_due.pop_front();
    flag_field("going_forward", want.going_forward, got.going_forward);
    flag_field("going_reverse", want.going_reverse, got.going_reverse);
    flag_field("brake_light", want.brake_light, got.brake_light);
    flag_field("armed", want.armed, got.armed);
  endfunction
endclass

module tb_esc_drive_mode_tracker_top;

  localparam int CNT_W          = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  // index past the register list, the block must ignore it
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst;

  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  drive_mode_scoreboard #(CNT_W) sb;

  int items_sent;
  int idle_cycles;
  int stall_run;
  int stall_pick;
  // when set, neither side idles: back-to-back transfers
  logic calm = 1'b0;

  esc_drive_mode_tracker_top #(.COUNT_BITS(CNT_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: every accepted transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Downstream stall pattern: runs of free and stalled cycles, mostly short,
  // now and then a long hold so the result register backs up into item_stall.
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (calm) begin
      result_stall <= 1'b0;
      stall_run <= 8;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        result_stall <= 1'b0;
        stall_run <= $urandom_range(0, 4);
      end else if (stall_pick < 96) begin
        result_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        result_stall <= 1'b1;
        stall_run <= $urandom_range(10, 40);
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Sender gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hold draws: mostly tiny so the countdowns expire within a few ticks.
  function automatic logic [9:0] pick_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 10'($urandom_range(0, 6));
    if (r < 90) return 10'($urandom_range(0, 40));
    return 10'($urandom_range(0, 1023));
  endfunction

  // One item transfer. Entered and left at a falling edge; the payload holds
  // while stalled.
  task automatic send(logic op, logic signed [7:0] thr, logic [9:0] bd, logic [9:0] rd);
    item_t it;
    int    gap;
    it.operation         = op;
    it.throttle          = thr;
    it.brake_hold_draw   = bd;
    it.reverse_hold_draw = rd;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic tick();
    send(OP_TICK, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
         10'($urandom_range(0, 1023)));
  endtask

  task automatic sample(logic signed [7:0] thr);
    send(OP_SAMPLE, thr, pick_draw(), pick_draw());
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Reconfigure only with the block idle: the result is registered and every item
  // gives a result, so an empty prediction queue plus a short pause suffices.
  task automatic configure(int mode, int wide, int narrow, int disarm, int fab, int rab);
    drain();
    repeat (2) @(negedge clk);
    write_reg(REG_CONTROLLER_MODE, CFG_DATA_BITS'(mode));
    write_reg(REG_NEUTRAL_BAND_WIDE, CFG_DATA_BITS'(wide));
    write_reg(REG_NEUTRAL_BAND_NARROW, CFG_DATA_BITS'(narrow));
    write_reg(REG_DISARM_TICKS, CFG_DATA_BITS'(disarm));
    write_reg(REG_FORWARD_AUTO_BRAKE_ON, CFG_DATA_BITS'(fab));
    write_reg(REG_REVERSE_AUTO_BRAKE_ON, CFG_DATA_BITS'(rab));
    write_reg(REG_SPARE, CFG_DATA_BITS'($urandom_range(0, 1023)));
    cfg_valid <= 1'b0;
  endtask

  // Random traffic built from driving maneuvers: push forward or back, let go,
  // let ticks run the countdowns out. Some raw noise mixed in.
  task automatic run_phase(int n);
    int target;
    int kind;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 3) drain();
      if ($urandom_range(0, 99) < 5) calm <= ~calm;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        repeat ($urandom_range(1, 3)) sample(8'($urandom_range(5, 100)));
        sample(8'(int'($urandom_range(0, 30)) - 15));
        repeat ($urandom_range(0, 8)) tick();
      end else if (kind < 50) begin
        repeat ($urandom_range(1, 3)) sample(8'(-int'($urandom_range(5, 100))));
        sample(8'(int'($urandom_range(0, 30)) - 15));
        repeat ($urandom_range(0, 8)) tick();
      end else if (kind < 75) begin
        // forward, pull back (brake or reverse), release, back again, release
        sample(8'($urandom_range(5, 100)));
        sample(8'(-int'($urandom_range(5, 100))));
        sample(8'(int'($urandom_range(0, 30)) - 15));
        repeat ($urandom_range(0, 3)) tick();
        sample(8'(-int'($urandom_range(5, 100))));
        sample(8'(int'($urandom_range(0, 30)) - 15));
        repeat ($urandom_range(0, 8)) tick();
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 10)) tick();
      end else begin
        repeat ($urandom_range(1, 4))
          send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      end
    end
    calm <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.clear();
    items_sent  = 0;
    idle_cycles = 0;
    stall_run   = 0;
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk through the reset settings (mode 2, bands 12/8).
    tick();                         // tick with junk in the ignored fields
    send(OP_SAMPLE, 8'sd0, 10'd0, 10'd0);
    send(OP_SAMPLE, 8'sd11, 10'd0, 10'd0);      // just inside the wide band
    send(OP_SAMPLE, 8'sd12, 10'd0, 10'd0);      // on the band edge: forward, armed
    send(OP_SAMPLE, 8'sd8, 10'd0, 10'd0);       // narrow band edge: still driving
    send(OP_SAMPLE, 8'sd7, 10'd0, 10'd1023);    // release, zero brake draw -> one tick
    tick();                                     // auto brake ends
    send(OP_SAMPLE, -8'sd128, 10'd5, 10'd5);    // magnitude 128 back while armed: brake
    send(OP_SAMPLE, -8'sd5, 10'd5, 10'd5);      // release with no hold: disarm
    send(OP_SAMPLE, -8'sd100, 10'd5, 10'd5);    // not armed: reverse
    send(OP_SAMPLE, 8'sd0, 10'd1023, 10'd0);    // hold reverse one tick, long brake
    tick();
    send(OP_SAMPLE, 8'sd127, 10'd1023, 10'd1023);
    send(OP_SAMPLE, -8'sd12, 10'd0, 10'd0);     // back while armed: brake
    send(OP_SAMPLE, 8'sd1, 10'd0, 10'd0);
    send(OP_SAMPLE, -8'sd100, 10'd0, 10'd0);
    send(OP_SAMPLE, 8'sd3, 10'd2, 10'd3);
    send(OP_SAMPLE, 8'sd0, 10'd9, 10'd9);       // reverse hold already running
    repeat (3) tick();
    send(OP_SAMPLE, -8'sd11, 10'd0, 10'd0);     // in neutral again: wide band applies

    // Neutral timeout mode with a short disarm.
    configure(int'(MODE_FWD_BRAKE_REV_TMO), 12, 8, 3, 1, 1);
    run_phase(300);
    // Band extremes: wide 255 keeps it in neutral for good.
    calm <= 1'b1;
    configure(int'(MODE_FWD_REV), 255, 0, 1023, 0, 0);
    run_phase(60);
    // wide 0 / narrow 255: every sample flips between drive and neutral.
    configure(int'(MODE_FWD_REV), 0, 255, 1, 1, 0);
    run_phase(150);
    configure(int'(MODE_FWD_BRAKE), 20, 5, 512, 0, 1);
    run_phase(250);
    // disarm of zero counts as one tick
    configure(int'(MODE_FWD_BRAKE_REV_TMO), 10, 10, 0, 1, 1);
    run_phase(250);
    configure($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 1023), $urandom_range(0, 1), $urandom_range(0, 1));
    run_phase(250);
    configure(int'(MODE_FWD_BRAKE_REV_TMO), 15, 3, 1023, 1, 1);
    run_phase(150);

    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
